// ===== rtl/bgts_pkg.sv =====
package bgts_pkg;

	localparam int WI_W   = 24;
	localparam int TILE_W = 12;
	localparam int KT_W   = 16;
	localparam int KG_W   = 25;
	localparam int KPG_W  = 6;
	localparam int ORD_W  = 3;
	localparam int CIDX_W = 3;
	localparam int CDAT_W = 16;

	localparam logic [ORD_W-1:0] ORD_JIK = 3'd0;
	localparam logic [ORD_W-1:0] ORD_IJK = 3'd1;
	localparam logic [ORD_W-1:0] ORD_JKI = 3'd2;
	localparam logic [ORD_W-1:0] ORD_IKJ = 3'd3;
	localparam logic [ORD_W-1:0] ORD_KJI = 3'd4;
	localparam logic [ORD_W-1:0] ORD_KIJ = 3'd5;

	localparam logic [CIDX_W-1:0] REG_LOOP_ORDER     = 3'd0;
	localparam logic [CIDX_W-1:0] REG_COUNT_I        = 3'd1;
	localparam logic [CIDX_W-1:0] REG_COUNT_J        = 3'd2;
	localparam logic [CIDX_W-1:0] REG_COUNT_K_GROUPS = 3'd3;
	localparam logic [CIDX_W-1:0] REG_K_PER_GROUP    = 3'd4;
	localparam logic [CIDX_W-1:0] REG_K_TILES_TOTAL  = 3'd5;

	localparam logic KIND_CALL  = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_LD,
		ST_DIV1,
		ST_DIV2,
		ST_ADD,
		ST_BASE,
		ST_FLUSH_OLD,
		ST_CALLS,
		ST_FLUSH_NEW
	} state_t;

	typedef struct packed {
		logic [ORD_W-1:0]  order;
		logic [TILE_W-1:0] ni;
		logic [TILE_W-1:0] nj;
		logic [TILE_W-1:0] nk;
		logic [KPG_W-1:0]  kpg;
		logic [KPG_W-1:0]  calls;
		logic [KT_W-1:0]   ktt;
	} cfg_t;

	typedef struct packed {
		logic            start;
		logic [WI_W-1:0] dividend;
		logic [WI_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [WI_W-1:0] quot;
		logic [WI_W-1:0] rem;
	} div_rsp_t;

endpackage

// ===== rtl/bgts_if.sv =====
interface bgts_in_if;
	import bgts_pkg::*;
	logic              valid;
	logic              ready;
	logic [WI_W-1:0]   work_index;
	logic [TILE_W-1:0] offset_i;
	logic [TILE_W-1:0] offset_j;
	logic [TILE_W-1:0] offset_k;
	logic              range_first;
	logic              range_last;

	modport source (output valid, work_index, offset_i, offset_j, offset_k, range_first,
		range_last, input ready);
	modport sink (input valid, work_index, offset_i, offset_j, offset_k, range_first,
		range_last, output ready);
endinterface

interface bgts_out_if;
	import bgts_pkg::*;
	logic              valid;
	logic              ready;
	logic              item_kind;
	logic [TILE_W-1:0] tile_i;
	logic [TILE_W-1:0] tile_j;
	logic [KT_W-1:0]   k_tile;
	logic              prefetch;
	logic              last_of_run;

	modport source (output valid, item_kind, tile_i, tile_j, k_tile, prefetch, last_of_run,
		input ready);
	modport sink (input valid, item_kind, tile_i, tile_j, k_tile, prefetch, last_of_run,
		output ready);
endinterface

interface bgts_cfg_if;
	import bgts_pkg::*;
	logic              valid;
	logic              ready;
	logic [CIDX_W-1:0] index;
	logic [CDAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/bgts_cfg.sv =====
module bgts_cfg #(
	parameter int MAX_K_PER_GROUP = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	bgts_cfg_if.sink          cfg,
	output bgts_pkg::cfg_t    regs
);
	import bgts_pkg::*;

	localparam logic [KPG_W-1:0] KPG_MAX = KPG_W'(MAX_K_PER_GROUP);

	logic [ORD_W-1:0]  order_q;
	logic [TILE_W-1:0] ni_q;
	logic [TILE_W-1:0] nj_q;
	logic [TILE_W-1:0] nk_q;
	logic [KPG_W-1:0]  kpg_q;
	logic [KT_W-1:0]   ktt_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORD_JIK;
			ni_q    <= TILE_W'(1);
			nj_q    <= TILE_W'(1);
			nk_q    <= TILE_W'(1);
			kpg_q   <= KPG_W'(1);
			ktt_q   <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_LOOP_ORDER:     order_q <= cfg.data[ORD_W-1:0];
				REG_COUNT_I:        ni_q    <= cfg.data[TILE_W-1:0];
				REG_COUNT_J:        nj_q    <= cfg.data[TILE_W-1:0];
				REG_COUNT_K_GROUPS: nk_q    <= cfg.data[TILE_W-1:0];
				REG_K_PER_GROUP:    kpg_q   <= cfg.data[KPG_W-1:0];
				REG_K_TILES_TOTAL:  ktt_q   <= cfg.data[KT_W-1:0];
				default: ;
			endcase
		end
	end

	// zero i, j and k-group counts act as one
	always_comb begin
		regs.order = order_q;
		regs.ni    = (ni_q == '0) ? TILE_W'(1) : ni_q;
		regs.nj    = (nj_q == '0) ? TILE_W'(1) : nj_q;
		regs.nk    = (nk_q == '0) ? TILE_W'(1) : nk_q;
		regs.kpg   = kpg_q;
		regs.calls = (kpg_q > KPG_MAX) ? KPG_MAX : kpg_q;
		regs.ktt   = ktt_q;
	end

endmodule

// ===== rtl/bgts_div.sv =====
module bgts_div (
	input  logic                clk,
	input  logic                arst_n,
	input  bgts_pkg::div_req_t  req,
	output bgts_pkg::div_rsp_t  rsp
);
	import bgts_pkg::*;

	localparam logic [4:0] LAST = 5'(WI_W - 1);

	logic            busy_q;
	logic            done_q;
	logic [4:0]      cnt_q;
	logic [WI_W-1:0] quot_q;
	logic [WI_W-1:0] rem_q;
	logic [WI_W-1:0] div_q;
	logic [WI_W:0]   trial;
	logic [WI_W:0]   diff;
	logic            ge;

	assign trial = {rem_q, quot_q[WI_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			rem_q  <= ge ? diff[WI_W-1:0] : trial[WI_W-1:0];
			quot_q <= {quot_q[WI_W-2:0], ge};
		end else if (req.start) begin
			rem_q  <= '0;
			quot_q <= req.dividend;
			div_q  <= req.divisor;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q) else $error("divider started while busy");

endmodule

// ===== rtl/blocked_gemm_tile_scheduler.sv =====
// Blocked GEMM tile scheduler.
// req carries one work word: a linear work index, outer block offsets and
// range-first/range-last marks. rsp carries result words: flushes of a C
// tile and kernel calls with their k tile and prefetch flag; last_of_run
// marks the final word of a work word. cfg writes the six control
// registers; the user must do so only while the block is idle, which the
// block itself does not enforce; cfg is always ready. A work word is split
// by a 12x12 multiply and two passes of one shared 24-step restoring
// divider. Result words are registered; each word after the first follows
// in the next cycle while rsp is ready. A work word yields up to 34 result
// words; req is not ready while it is processed.
// A stall on rsp holds the output register and halts the word sequence.
// Reset returns the registers to their defaults and the held tile to 0.
module blocked_gemm_tile_scheduler #(
	parameter int MAX_K_PER_GROUP = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	bgts_in_if.sink    req,
	bgts_out_if.source rsp,
	bgts_cfg_if.sink   cfg
);
	import bgts_pkg::*;

	cfg_t     regs;
	div_req_t dreq;
	div_rsp_t drsp;
	state_t   state_q, state_d;

	logic [WI_W-1:0]   w_q;
	logic [TILE_W-1:0] oi_q, oj_q, ok_q;
	logic              first_q, last_q;
	logic [WI_W-1:0]   prod_q;
	logic [TILE_W-1:0] d2_q;
	logic [WI_W-1:0]   q1_q;
	logic [TILE_W-1:0] ti_q, tj_q;
	logic [KG_W-1:0]   kg_q;
	logic [KT_W-1:0]   kt_q;
	logic              pf_q;
	logic [TILE_W-1:0] held_i_q, held_j_q;
	logic [TILE_W-1:0] old_i_q, old_j_q;
	logic [KPG_W-1:0]  c_q;

	logic              ov_q;
	logic              kind_q, pfo_q, lor_q;
	logic [TILE_W-1:0] oti_q, otj_q;
	logic [KT_W-1:0]   okt_q;

	logic [TILE_W-1:0] fa, fb, fd2;
	logic [WI_W-1:0]   di, dj, dk;
	logic              need_old, free, last_call;
	state_t            after_old;
	logic [KPG_W+KT_W-1:0] base;

	logic              load_item;
	logic              it_kind, it_pf, it_lor;
	logic [TILE_W-1:0] it_i, it_j;
	logic [KT_W-1:0]   it_kt;

	bgts_cfg #(.MAX_K_PER_GROUP(MAX_K_PER_GROUP)) u_cfg (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .regs(regs)
	);

	bgts_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	always_comb begin
		case (regs.order)
			ORD_IJK: begin fa = regs.nj; fb = regs.nk; fd2 = regs.nk; end
			ORD_JKI: begin fa = regs.nk; fb = regs.ni; fd2 = regs.ni; end
			ORD_IKJ: begin fa = regs.nk; fb = regs.nj; fd2 = regs.nj; end
			ORD_KJI: begin fa = regs.nj; fb = regs.ni; fd2 = regs.ni; end
			ORD_KIJ: begin fa = regs.ni; fb = regs.nj; fd2 = regs.nj; end
			default: begin fa = regs.ni; fb = regs.nk; fd2 = regs.nk; end
		endcase
	end

	always_comb begin
		case (regs.order)
			ORD_IJK: begin di = q1_q;      dj = drsp.quot; dk = drsp.rem;  end
			ORD_JKI: begin dj = q1_q;      dk = drsp.quot; di = drsp.rem;  end
			ORD_IKJ: begin di = q1_q;      dk = drsp.quot; dj = drsp.rem;  end
			ORD_KJI: begin dk = q1_q;      dj = drsp.quot; di = drsp.rem;  end
			ORD_KIJ: begin dk = q1_q;      di = drsp.quot; dj = drsp.rem;  end
			default: begin dj = q1_q;      di = drsp.quot; dk = drsp.rem;  end
		endcase
	end

	assign base      = (KPG_W+KT_W)'(regs.kpg) * (KPG_W+KT_W)'(kg_q[KT_W-1:0]);
	assign need_old  = !first_q && ((ti_q != held_i_q) || (tj_q != held_j_q));
	assign free      = !ov_q || rsp.ready;
	assign last_call = (c_q + KPG_W'(1)) == regs.calls;
	assign after_old = (regs.calls != '0) ? ST_CALLS : (last_q ? ST_FLUSH_NEW : ST_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:      if (req.valid) state_d = ST_MUL;
			ST_MUL:       state_d = ST_LD;
			ST_LD:        state_d = ST_DIV1;
			ST_DIV1:      if (drsp.done) state_d = ST_DIV2;
			ST_DIV2:      if (drsp.done) state_d = ST_ADD;
			ST_ADD:       state_d = ST_BASE;
			ST_BASE:      state_d = need_old ? ST_FLUSH_OLD : after_old;
			ST_FLUSH_OLD: if (free) state_d = after_old;
			ST_CALLS: begin
				if (free && last_call) state_d = last_q ? ST_FLUSH_NEW : ST_IDLE;
			end
			ST_FLUSH_NEW: if (free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		dreq.start    = 1'b0;
		dreq.dividend = w_q;
		dreq.divisor  = prod_q;
		load_item     = 1'b0;
		it_kind       = KIND_FLUSH;
		it_i          = ti_q;
		it_j          = tj_q;
		it_kt         = '0;
		it_pf         = 1'b0;
		it_lor        = 1'b1;
		case (state_q)
			ST_LD: dreq.start = 1'b1;
			ST_DIV1: begin
				dreq.start    = drsp.done;
				dreq.dividend = drsp.rem;
				dreq.divisor  = {{(WI_W-TILE_W){1'b0}}, d2_q};
			end
			ST_FLUSH_OLD: begin
				load_item = free;
				it_i      = old_i_q;
				it_j      = old_j_q;
				it_lor    = (regs.calls == '0) && !last_q;
			end
			ST_CALLS: begin
				load_item = free;
				it_kind   = KIND_CALL;
				it_kt     = kt_q + {{(KT_W-KPG_W){1'b0}}, c_q};
				it_pf     = pf_q;
				it_lor    = last_call && !last_q;
			end
			ST_FLUSH_NEW: load_item = free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			held_i_q <= '0;
			held_j_q <= '0;
			ov_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_BASE) begin
				held_i_q <= ti_q;
				held_j_q <= tj_q;
			end
			if (load_item) ov_q <= 1'b1;
			else if (rsp.ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			w_q     <= req.work_index;
			oi_q    <= req.offset_i;
			oj_q    <= req.offset_j;
			ok_q    <= req.offset_k;
			first_q <= req.range_first;
			last_q  <= req.range_last;
		end
		if (state_q == ST_MUL) begin
			prod_q <= WI_W'(fa) * WI_W'(fb);
			d2_q   <= fd2;
		end
		if (state_q == ST_DIV1 && drsp.done) q1_q <= drsp.quot;
		if (state_q == ST_ADD) begin
			ti_q <= oi_q + di[TILE_W-1:0];
			tj_q <= oj_q + dj[TILE_W-1:0];
			kg_q <= {{(KG_W-TILE_W){1'b0}}, ok_q} + {1'b0, dk};
		end
		if (state_q == ST_BASE) begin
			kt_q    <= base[KT_W-1:0];
			pf_q    <= ({1'b0, kg_q} + (KG_W+1)'(2)) < {{(KG_W+1-KT_W){1'b0}}, regs.ktt};
			old_i_q <= held_i_q;
			old_j_q <= held_j_q;
			c_q     <= '0;
		end
		if (state_q == ST_CALLS && free) c_q <= c_q + KPG_W'(1);
		if (load_item) begin
			kind_q <= it_kind;
			oti_q  <= it_i;
			otj_q  <= it_j;
			okt_q  <= it_kt;
			pfo_q  <= it_pf;
			lor_q  <= it_lor;
		end
	end

	assign req.ready       = (state_q == ST_IDLE);
	assign rsp.valid       = ov_q;
	assign rsp.item_kind   = kind_q;
	assign rsp.tile_i      = oti_q;
	assign rsp.tile_j      = otj_q;
	assign rsp.k_tile      = okt_q;
	assign rsp.prefetch    = pfo_q;
	assign rsp.last_of_run = lor_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == ST_MUL)) else $error("accept did not start");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !rsp.ready) |-> !load_item) else $error("output word overwritten");

	a_call_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CALLS) |-> (c_q < regs.calls)) else $error("call count overrun");

endmodule
